// ===== sv/bpbd_pkg.sv =====
// Shared types, constants and widths for the box-pair binary descriptor block.
package bpbd_pkg;

   // Integral image and descriptor limits
   localparam int MAX_COLS     = 256;
   localparam int MAX_ROWS     = 256;
   localparam int MAX_LEARNERS = 512;

   // Coordinate and address widths
   localparam int COL_W  = $clog2(MAX_COLS);
   localparam int ROW_W  = $clog2(MAX_ROWS);
   localparam int CRD_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
   localparam int DIM_W  = CRD_W + 1;
   localparam int ADDR_W = ROW_W + COL_W;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;

   // Datapath widths
   localparam int DATA_W = 24;
   localparam int SUM_W  = DATA_W + 3;
   localparam int AREA_W = 2 * CRD_W;
   localparam int THR_W  = 16;
   localparam int PROD_W = SUM_W + AREA_W + 1;
   localparam int DIFF_W = PROD_W + 1;
   localparam int AA_W   = 2 * AREA_W;
   localparam int RHS_W  = THR_W + AA_W + 1;
   localparam int CMP_W  = DIFF_W + 7;

   // Learner counting
   localparam int CNT_W = $clog2(MAX_LEARNERS);
   localparam int LRN_W = CNT_W + 1;

   // Configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_COLS = 2'd0,
      CSR_IMAGE_ROWS = 2'd1,
      CSR_LEARNERS   = 2'd2
   } bpbd_csr_type;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   typedef struct packed {
      logic                    kind;
      logic [7:0]              cell_row;
      logic [7:0]              cell_col;
      logic [23:0]             cell_value;
      logic signed [11:0]      first_x;
      logic signed [11:0]      first_y;
      logic signed [11:0]      second_x;
      logic signed [11:0]      second_y;
      logic [5:0]              box_radius;
      logic signed [THR_W-1:0] threshold;
   } bpbd_req_type;

   typedef struct packed {
      logic [7:0] desc_byte;
      logic       last_byte;
   } bpbd_rsp_type;

   // Integral memory access
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr_a;
      logic [ADDR_W-1:0] raddr_b;
   } bpbd_mem_req_type;

   // Comparison unit request and result
   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] sum1;
      logic signed [SUM_W-1:0] sum2;
      logic [AREA_W-1:0]       area1;
      logic [AREA_W-1:0]       area2;
      logic signed [THR_W-1:0] threshold;
   } bpbd_calc_req_type;

   typedef struct packed {
      logic valid;
      logic result_bit;
   } bpbd_calc_rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_READ,
      ST_DRAIN,
      ST_CALC,
      ST_WAIT
   } bpbd_state_type;

endpackage

// ===== sv/bpbd_store.sv =====
// Integral image memory: one write port, two registered read ports.
module bpbd_store (
   input  logic                         clock,
   input  bpbd_pkg::bpbd_mem_req_type   mem_req,
   output logic [bpbd_pkg::DATA_W-1:0]  rd_a_ff,
   output logic [bpbd_pkg::DATA_W-1:0]  rd_b_ff
);

   logic [bpbd_pkg::DATA_W-1:0] store_ff [bpbd_pkg::DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // Read ports, registered
   always_ff @(posedge clock) begin
      rd_a_ff <= store_ff[mem_req.raddr_a];
      rd_b_ff <= store_ff[mem_req.raddr_b];
   end

endmodule

// ===== sv/bpbd_calc.sv =====
// Three-stage exact comparison of the two box means against the threshold.
module bpbd_calc (
   input  logic                        clock,
   input  logic                        reset,
   input  bpbd_pkg::bpbd_calc_req_type calc_req,
   output bpbd_pkg::bpbd_calc_rsp_type calc_rsp
);

   logic signed [bpbd_pkg::PROD_W-1:0] p1_in, p1_ff, p2_in, p2_ff;
   logic [bpbd_pkg::AA_W-1:0]          aa_in, aa_ff;
   logic signed [bpbd_pkg::THR_W-1:0]  thr_ff;
   logic signed [bpbd_pkg::DIFF_W-1:0] diff_in, diff_ff;
   logic signed [bpbd_pkg::RHS_W-1:0]  rhs_in, rhs_ff;
   logic signed [bpbd_pkg::CMP_W-1:0]  lhs_c, rhs_c;
   logic                               bit_in, bit_ff;
   logic                               v1_ff, v2_ff, v3_ff;

   // Stage 1: cross products sum1*area2, sum2*area1 and area product
   always_comb begin
      p1_in = calc_req.sum1 * $signed({1'b0, calc_req.area2});
      p2_in = calc_req.sum2 * $signed({1'b0, calc_req.area1});
      aa_in = calc_req.area1 * calc_req.area2;
   end

   // Stage 2: difference and threshold scaled by both areas
   always_comb begin
      diff_in = p1_ff - p2_ff;
      rhs_in  = thr_ff * $signed({1'b0, aa_ff});
   end

   // Stage 3: 64*diff <= rhs
   always_comb begin
      lhs_c  = {diff_ff[bpbd_pkg::DIFF_W-1], diff_ff, 6'b0};
      rhs_c  = {{(bpbd_pkg::CMP_W - bpbd_pkg::RHS_W){rhs_ff[bpbd_pkg::RHS_W-1]}}, rhs_ff};
      bit_in = (lhs_c <= rhs_c);
   end

   always_ff @(posedge clock) begin
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      aa_ff   <= aa_in;
      thr_ff  <= calc_req.threshold;
      diff_ff <= diff_in;
      rhs_ff  <= rhs_in;
      bit_ff  <= bit_in;
   end

   // Stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= calc_req.start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   assign calc_rsp.valid      = v3_ff;
   assign calc_rsp.result_bit = bit_ff;

endmodule

// ===== sv/box_pair_binary_descriptor_top.sv =====
// Top level: sequencer, box clamping, corner reads and descriptor byte packing.
//
// Load items write one integral cell; busy stays low, so loads can be
// issued every cycle while no evaluate runs. An evaluate item holds busy
// high until it is done: the clamp state clamps both boxes, the read state
// issues the eight corner reads over the two read ports of the integral
// memory, the drain state drains the last read, and the three-stage multiply
// and compare unit runs through the calc and wait states. Every eighth
// evaluate item produces one result on rsp_strobe/rsp_item for exactly one
// cycle, the first cycle after busy falls; the receiver cannot hold it off.
// The integral memory needs no clearing after reset: cells must be loaded
// before they are read.
// Configuration writes are always ready and must only be issued while busy
// is low.
module box_pair_binary_descriptor_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  bpbd_pkg::bpbd_req_type            req_item,
   output logic                              rsp_strobe,
   output bpbd_pkg::bpbd_rsp_type            rsp_item,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpbd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bpbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   typedef struct packed {
      logic [bpbd_pkg::CRD_W-1:0] lo;
      logic [bpbd_pkg::CRD_W-1:0] hi;
   } bpbd_span_type;

   // Clamp one axis: low edge into [0, dim-2], high edge into [1, dim-1]
   function automatic bpbd_span_type clamp_axis(
      input logic signed [11:0]         c,
      input logic [5:0]                 r,
      input logic [bpbd_pkg::DIM_W-1:0] dim
   );
      logic signed [13:0] lo_v;
      logic signed [13:0] hi_v;
      logic signed [13:0] dim_v;
      logic signed [13:0] dm1_v;
      bpbd_span_type      s;
      lo_v  = {{2{c[11]}}, c} - {8'd0, r};
      hi_v  = {{2{c[11]}}, c} + {8'd0, r} + 14'sd1;
      dim_v = {{(14 - bpbd_pkg::DIM_W){1'b0}}, dim};
      dm1_v = dim_v - 14'sd1;
      if (lo_v[13]) begin
         s.lo = '0;
      end else if (lo_v >= dm1_v) begin
         s.lo = bpbd_pkg::CRD_W'(dim - bpbd_pkg::DIM_W'(2));
      end else begin
         s.lo = lo_v[bpbd_pkg::CRD_W-1:0];
      end
      if (hi_v <= 14'sd0) begin
         s.hi = bpbd_pkg::CRD_W'(1);
      end else if (hi_v >= dim_v) begin
         s.hi = bpbd_pkg::CRD_W'(dim - bpbd_pkg::DIM_W'(1));
      end else begin
         s.hi = hi_v[bpbd_pkg::CRD_W-1:0];
      end
      return s;
   endfunction

   bpbd_pkg::bpbd_state_type    state_ff, state_in;
   bpbd_pkg::bpbd_req_type      item_ff;
   bpbd_pkg::bpbd_mem_req_type  mem_req;
   bpbd_pkg::bpbd_calc_req_type calc_req;
   bpbd_pkg::bpbd_calc_rsp_type calc_rsp;
   bpbd_pkg::bpbd_rsp_type      rsp_item_ff;

   logic [bpbd_pkg::DIM_W-1:0]      cols_ff, rows_ff;
   logic [bpbd_pkg::LRN_W-1:0]      learners_ff;
   logic [bpbd_pkg::DIM_W-1:0]      eff_cols, eff_rows;
   logic [bpbd_pkg::LRN_W-1:0]      eff_learners;

   logic                            accept;
   logic                            load_in_range;
   logic [1:0]                      rd_cnt_ff;
   logic                            rd_valid_ff, rd_valid_in;
   logic [1:0]                      rd_tag_ff;
   logic [bpbd_pkg::DATA_W-1:0]     rd_a, rd_b;
   logic [bpbd_pkg::DATA_W:0]       rd_pair;

   bpbd_span_type                   xs_ff [2];
   bpbd_span_type                   ys_ff [2];
   logic signed [bpbd_pkg::SUM_W-1:0] sum_ff [2];
   logic [bpbd_pkg::AREA_W-1:0]     area_ff [2];
   logic                            box_sel;

   logic [7:0]                      acc_ff, acc_in;
   logic [bpbd_pkg::CNT_W-1:0]      count_ff;
   logic [bpbd_pkg::LRN_W-1:0]      count_next;
   logic                            rsp_strobe_ff;

   // Effective register values
   always_comb begin
      eff_cols = cols_ff;
      if (cols_ff < bpbd_pkg::DIM_W'(2)) begin
         eff_cols = bpbd_pkg::DIM_W'(2);
      end else if (cols_ff > bpbd_pkg::DIM_W'(bpbd_pkg::MAX_COLS)) begin
         eff_cols = bpbd_pkg::DIM_W'(bpbd_pkg::MAX_COLS);
      end
      eff_rows = rows_ff;
      if (rows_ff < bpbd_pkg::DIM_W'(2)) begin
         eff_rows = bpbd_pkg::DIM_W'(2);
      end else if (rows_ff > bpbd_pkg::DIM_W'(bpbd_pkg::MAX_ROWS)) begin
         eff_rows = bpbd_pkg::DIM_W'(bpbd_pkg::MAX_ROWS);
      end
      eff_learners = learners_ff;
      if (learners_ff < bpbd_pkg::LRN_W'(8)) begin
         eff_learners = bpbd_pkg::LRN_W'(8);
      end else if (learners_ff > bpbd_pkg::LRN_W'(bpbd_pkg::MAX_LEARNERS)) begin
         eff_learners = bpbd_pkg::LRN_W'(bpbd_pkg::MAX_LEARNERS);
      end
      eff_learners[2:0] = 3'd0;
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff     <= bpbd_pkg::DIM_W'(256);
         rows_ff     <= bpbd_pkg::DIM_W'(256);
         learners_ff <= bpbd_pkg::LRN_W'(256);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpbd_pkg::CSR_IMAGE_COLS: cols_ff     <= csr_wdata[bpbd_pkg::DIM_W-1:0];
            bpbd_pkg::CSR_IMAGE_ROWS: rows_ff     <= csr_wdata[bpbd_pkg::DIM_W-1:0];
            bpbd_pkg::CSR_LEARNERS:   learners_ff <= csr_wdata[bpbd_pkg::LRN_W-1:0];
            default: ;
         endcase
      end
   end

   // Item acceptance
   assign accept        = start && !busy;
   assign load_in_range = ({1'b0, req_item.cell_row} < eff_rows) &&
                          ({1'b0, req_item.cell_col} < eff_cols);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bpbd_pkg::ST_IDLE: begin
            if (accept && req_item.kind == bpbd_pkg::KIND_EVAL) begin
               state_in = bpbd_pkg::ST_CLAMP;
            end
         end
         bpbd_pkg::ST_CLAMP: state_in = bpbd_pkg::ST_READ;
         bpbd_pkg::ST_READ: begin
            if (rd_cnt_ff == 2'd3) begin
               state_in = bpbd_pkg::ST_DRAIN;
            end
         end
         bpbd_pkg::ST_DRAIN: state_in = bpbd_pkg::ST_CALC;
         bpbd_pkg::ST_CALC:  state_in = bpbd_pkg::ST_WAIT;
         bpbd_pkg::ST_WAIT: begin
            if (calc_rsp.valid) begin
               state_in = bpbd_pkg::ST_IDLE;
            end
         end
         default: state_in = bpbd_pkg::ST_IDLE;
      endcase
   end

   // State outputs: busy, memory access, compare start
   assign box_sel = rd_cnt_ff[1];

   always_comb begin
      busy           = (state_ff != bpbd_pkg::ST_IDLE);
      mem_req.we     = 1'b0;
      mem_req.waddr  = {req_item.cell_row[bpbd_pkg::ROW_W-1:0],
                        req_item.cell_col[bpbd_pkg::COL_W-1:0]};
      mem_req.wdata  = req_item.cell_value;
      mem_req.raddr_a = '0;
      mem_req.raddr_b = '0;
      rd_valid_in    = 1'b0;
      calc_req.start     = 1'b0;
      calc_req.sum1      = sum_ff[0];
      calc_req.sum2      = sum_ff[1];
      calc_req.area1     = area_ff[0];
      calc_req.area2     = area_ff[1];
      calc_req.threshold = item_ff.threshold;
      case (state_ff)
         bpbd_pkg::ST_IDLE: begin
            mem_req.we = accept && (req_item.kind == bpbd_pkg::KIND_LOAD) && load_in_range;
         end
         bpbd_pkg::ST_READ: begin
            rd_valid_in = 1'b1;
            if (rd_cnt_ff[0]) begin
               mem_req.raddr_a = {ys_ff[box_sel].lo[bpbd_pkg::ROW_W-1:0],
                                  xs_ff[box_sel].hi[bpbd_pkg::COL_W-1:0]};
               mem_req.raddr_b = {ys_ff[box_sel].hi[bpbd_pkg::ROW_W-1:0],
                                  xs_ff[box_sel].lo[bpbd_pkg::COL_W-1:0]};
            end else begin
               mem_req.raddr_a = {ys_ff[box_sel].lo[bpbd_pkg::ROW_W-1:0],
                                  xs_ff[box_sel].lo[bpbd_pkg::COL_W-1:0]};
               mem_req.raddr_b = {ys_ff[box_sel].hi[bpbd_pkg::ROW_W-1:0],
                                  xs_ff[box_sel].hi[bpbd_pkg::COL_W-1:0]};
            end
         end
         bpbd_pkg::ST_CALC: calc_req.start = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= bpbd_pkg::ST_IDLE;
         rd_cnt_ff   <= 2'd0;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
         if (state_ff == bpbd_pkg::ST_READ) begin
            rd_cnt_ff <= rd_cnt_ff + 2'd1;
         end else begin
            rd_cnt_ff <= 2'd0;
         end
      end
   end

   // Item capture, clamping, areas
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
      if (state_ff == bpbd_pkg::ST_CLAMP) begin
         xs_ff[0] <= clamp_axis(item_ff.first_x,  item_ff.box_radius, eff_cols);
         ys_ff[0] <= clamp_axis(item_ff.first_y,  item_ff.box_radius, eff_rows);
         xs_ff[1] <= clamp_axis(item_ff.second_x, item_ff.box_radius, eff_cols);
         ys_ff[1] <= clamp_axis(item_ff.second_y, item_ff.box_radius, eff_rows);
      end
      if (state_ff == bpbd_pkg::ST_READ) begin
         area_ff[0] <= bpbd_pkg::AREA_W'(xs_ff[0].hi - xs_ff[0].lo) *
                       bpbd_pkg::AREA_W'(ys_ff[0].hi - ys_ff[0].lo);
         area_ff[1] <= bpbd_pkg::AREA_W'(xs_ff[1].hi - xs_ff[1].lo) *
                       bpbd_pkg::AREA_W'(ys_ff[1].hi - ys_ff[1].lo);
      end
      rd_tag_ff <= rd_cnt_ff;
   end

   // Integral memory
   bpbd_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_a_ff (rd_a),
      .rd_b_ff (rd_b)
   );

   // Box sums: phase even adds A+D, phase odd subtracts B+C
   assign rd_pair = {1'b0, rd_a} + {1'b0, rd_b};

   always_ff @(posedge clock) begin
      if (state_ff == bpbd_pkg::ST_CLAMP) begin
         sum_ff[0] <= '0;
         sum_ff[1] <= '0;
      end else if (rd_valid_ff) begin
         if (rd_tag_ff[0]) begin
            sum_ff[rd_tag_ff[1]] <= sum_ff[rd_tag_ff[1]] - bpbd_pkg::SUM_W'(rd_pair);
         end else begin
            sum_ff[rd_tag_ff[1]] <= sum_ff[rd_tag_ff[1]] + bpbd_pkg::SUM_W'(rd_pair);
         end
      end
   end

   // Compare unit
   bpbd_calc u_calc (
      .clock    (clock),
      .reset    (reset),
      .calc_req (calc_req),
      .calc_rsp (calc_rsp)
   );

   // Bit packing, MSB first
   assign count_next = {1'b0, count_ff} + bpbd_pkg::LRN_W'(1);
   assign acc_in     = acc_ff | (8'(calc_rsp.result_bit) << (3'd7 - count_ff[2:0]));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= 8'd0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         if (state_ff == bpbd_pkg::ST_WAIT && calc_rsp.valid) begin
            if (count_next[2:0] == 3'd0) begin
               rsp_strobe_ff         <= 1'b1;
               rsp_item_ff.desc_byte <= acc_in;
               acc_ff                <= 8'd0;
               if (count_next >= eff_learners) begin
                  rsp_item_ff.last_byte <= 1'b1;
                  count_ff              <= '0;
               end else begin
                  rsp_item_ff.last_byte <= 1'b0;
                  count_ff              <= count_next[bpbd_pkg::CNT_W-1:0];
               end
            end else begin
               acc_ff   <= acc_in;
               count_ff <= count_next[bpbd_pkg::CNT_W-1:0];
            end
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // Loads only reach the memory while no evaluation is in flight
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> state_ff == bpbd_pkg::ST_IDLE)
      else $error("memory write while evaluating");

   // Compare results only arrive while the sequencer waits for them
   a_calc_wait: assert property (@(posedge clock) disable iff (reset)
      calc_rsp.valid |-> state_ff == bpbd_pkg::ST_WAIT)
      else $error("compare result outside wait state");

   // A byte is emitted only right after a completed learner
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(state_ff == bpbd_pkg::ST_WAIT && calc_rsp.valid))
      else $error("byte emitted without learner");

   // A descriptor-final byte restarts the learner count
   a_last_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_item_ff.last_byte) |-> count_ff == '0)
      else $error("count not restarted after last byte");

   // Corner reads return data only during the read and drain phases
   a_read_phase: assert property (@(posedge clock) disable iff (reset)
      rd_valid_ff |-> (state_ff == bpbd_pkg::ST_READ || state_ff == bpbd_pkg::ST_DRAIN))
      else $error("read data outside read window");

endmodule

// ===== tb/bpbd_checker.sv =====
// Checker for the box-pair descriptor block: predicts descriptor bytes and compares them.
`timescale 1ns / 100ps
module bpbd_checker
   import bpbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  bpbd_req_type          req_item,
   input  logic                  rsp_strobe,
   input  bpbd_rsp_type          rsp_item,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    bytes_outstanding
);

   // Shadow of the integral store and the block's registers
   bit [DATA_W-1:0] cell_mem [0:DEPTH-1];
   logic [8:0]      cols_cfg;
   logic [8:0]      rows_cfg;
   logic [9:0]      learners_cfg;
   logic [7:0]      bit_acc;
   int              learner_cnt;
   bpbd_rsp_type    expected_bytes [$];

   function automatic int sat_dim(logic [8:0] raw, int lim);
      if (raw < 2) return 2;
      if (raw > lim) return lim;
      return int'(raw);
   endfunction

   function automatic int descriptor_len();
      int n;
      n = int'(learners_cfg);
      if (n < 8) n = 8;
      if (n > MAX_LEARNERS) n = MAX_LEARNERS;
      return n - (n % 8);
   endfunction

   // Low edge goes to [0, dim-2], high edge to [1, dim-1]
   function automatic void clamp_span(input int c, input int r, input int dim,
                                      output int lo, output int hi);
      lo = c - r;
      hi = c + r + 1;
      if (lo < 0) lo = 0;
      else if (lo >= dim - 1) lo = dim - 2;
      if (hi <= 0) hi = 1;
      else if (hi >= dim) hi = dim - 1;
   endfunction

   function automatic longint corner(int y, int x);
      return longint'(cell_mem[y * MAX_COLS + x]);
   endfunction

   function automatic void box_sum(input int cx, input int cy, input int r,
                                   output longint sum, output longint area);
      int x0, x1, y0, y1;
      clamp_span(cx, r, sat_dim(cols_cfg, MAX_COLS), x0, x1);
      clamp_span(cy, r, sat_dim(rows_cfg, MAX_ROWS), y0, y1);
      sum  = corner(y0, x0) + corner(y1, x1) - corner(y0, x1) - corner(y1, x0);
      area = longint'(x1 - x0) * longint'(y1 - y0);
   endfunction

   // Exact mean comparison: 64*(s1*a2 - s2*a1) <= t*a1*a2
   function automatic bit learner_bit(bpbd_req_type it);
      longint s1, a1, s2, a2, lhs, rhs;
      int     r;
      r = int'(it.box_radius);
      box_sum(int'($signed(it.first_x)), int'($signed(it.first_y)), r, s1, a1);
      box_sum(int'($signed(it.second_x)), int'($signed(it.second_y)), r, s2, a2);
      lhs = (s1 * a2 - s2 * a1) * 64;
      rhs = longint'($signed(it.threshold)) * a1 * a2;
      return lhs <= rhs;
   endfunction

   // Pack one learner bit, MSB first; queue a byte every eighth learner
   function automatic void pack_learner(bit b);
      bpbd_rsp_type byte_out;
      bit_acc = bit_acc | (8'(b) << (7 - (learner_cnt % 8)));
      learner_cnt++;
      if (learner_cnt % 8 == 0) begin
         byte_out.desc_byte = bit_acc;
         byte_out.last_byte = (learner_cnt >= descriptor_len());
         expected_bytes.push_back(byte_out);
         bit_acc = '0;
         if (byte_out.last_byte) learner_cnt = 0;
      end
   endfunction

   always @(posedge clock) begin
      bpbd_rsp_type want;
      if (reset) begin
         cols_cfg       = 9'd256;
         rows_cfg       = 9'd256;
         learners_cfg   = 10'd256;
         bit_acc        = '0;
         learner_cnt    = 0;
         mismatch_count = 0;
         expected_bytes.delete();
      end else begin
         // Result side: compare with the oldest expected byte
         if (rsp_strobe) begin
            if (expected_bytes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected byte, expected none, actual desc_byte %02h last_byte %0b",
                        $time, rsp_item.desc_byte, rsp_item.last_byte);
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_item.desc_byte !== want.desc_byte) begin
                  mismatch_count++;
                  $display("%0t: desc_byte expected %02h actual %02h",
                           $time, want.desc_byte, rsp_item.desc_byte);
               end
               if (rsp_item.last_byte !== want.last_byte) begin
                  mismatch_count++;
                  $display("%0t: last_byte expected %0b actual %0b",
                           $time, want.last_byte, rsp_item.last_byte);
               end
            end
         end

         // Register writes
         if (csr_valid && csr_ready) begin
            case (bpbd_csr_type'(csr_index))
               CSR_IMAGE_COLS: cols_cfg     = csr_wdata[8:0];
               CSR_IMAGE_ROWS: rows_cfg     = csr_wdata[8:0];
               CSR_LEARNERS:   learners_cfg = csr_wdata[9:0];
               default: ;
            endcase
         end

         // Accepted item
         if (start && !busy) begin
            if (req_item.kind == KIND_LOAD) begin
               if (int'(req_item.cell_row) < sat_dim(rows_cfg, MAX_ROWS) &&
                   int'(req_item.cell_col) < sat_dim(cols_cfg, MAX_COLS))
                  cell_mem[int'(req_item.cell_row) * MAX_COLS + int'(req_item.cell_col)] =
                     req_item.cell_value;
            end else begin
               pack_learner(learner_bit(req_item));
            end
         end
      end
      bytes_outstanding = expected_bytes.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives loads, learners and register writes into the descriptor block.
`timescale 1ns / 100ps
module tb_top;
   import bpbd_pkg::*;

   localparam int SETTLE_CYCLES = 24;
   localparam int CYCLE_LIMIT   = 100000;
   localparam int BAND          = 8;
   localparam int FULL_LOAD_MAX = 24;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   bpbd_req_type          req_item;
   logic                  rsp_strobe;
   bpbd_rsp_type          rsp_item;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    bytes_outstanding;
   int                    cycle_count = 0;
   int                    burst_left;
   int                    img_cols;
   int                    img_rows;

   // Cells that hold loaded data are the product of these row and column sets
   bit                    row_ok [0:MAX_ROWS-1];
   bit                    col_ok [0:MAX_COLS-1];
   int unsigned           image  [0:MAX_ROWS-1][0:MAX_COLS-1];

   box_pair_binary_descriptor_top uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   bpbd_checker descriptor_check (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_item          (req_item),
      .rsp_strobe        (rsp_strobe),
      .rsp_item          (rsp_item),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic int clip_dim(int raw, int lim);
      raw = raw & 'h1FF;
      if (raw < 2) return 2;
      if (raw > lim) return lim;
      return raw;
   endfunction

   // Every field random; callers overwrite the ones that matter
   function automatic bpbd_req_type noise_item();
      bpbd_req_type it;
      it.kind       = 1'($urandom_range(0, 1));
      it.cell_row   = 8'($urandom);
      it.cell_col   = 8'($urandom);
      it.cell_value = 24'($urandom);
      it.first_x    = 12'($urandom);
      it.first_y    = 12'($urandom);
      it.second_x   = 12'($urandom);
      it.second_y   = 12'($urandom);
      it.box_radius = 6'($urandom);
      it.threshold  = 16'($urandom);
      return it;
   endfunction

   // Centre coordinate whose clamped box edges land on loaded cells
   function automatic int pick_coord(int dim, int r, bit is_col);
      int c, lo, hi;
      for (int tries = 0; tries < 64; tries++) begin
         case ($urandom_range(0, 7))
            0:       c = $urandom_range(0, 4095) - 2048;
            1:       c = $urandom_range(0, 1) ? 2047 : -2048;
            default: c = $urandom_range(0, dim + 2 * r + 2) - r - 1;
         endcase
         lo = c - r;
         hi = c + r + 1;
         lo = (lo < 0) ? 0 : (lo > dim - 2) ? dim - 2 : lo;
         hi = (hi < 1) ? 1 : (hi > dim - 1) ? dim - 1 : hi;
         if (is_col ? (col_ok[lo] && col_ok[hi]) : (row_ok[lo] && row_ok[hi])) return c;
      end
      return -2048;
   endfunction

   // Sender: bursts of items separated by random gaps
   task automatic send_item(input bpbd_req_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
         if (gap > 0) begin
            @(negedge clock);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic send_load(input int row, input int col, input int unsigned value);
      bpbd_req_type it;
      it            = noise_item();
      it.kind       = KIND_LOAD;
      it.cell_row   = 8'(row);
      it.cell_col   = 8'(col);
      it.cell_value = 24'(value);
      send_item(it);
   endtask

   task automatic send_eval(input int fx, input int fy, input int sx, input int sy,
                            input int r, input int thr);
      bpbd_req_type it;
      it            = noise_item();
      it.kind       = KIND_EVAL;
      it.first_x    = 12'(fx);
      it.first_y    = 12'(fy);
      it.second_x   = 12'(sx);
      it.second_y   = 12'(sy);
      it.box_radius = 6'(r);
      it.threshold  = 16'(thr);
      send_item(it);
   endtask

   // Load aimed at or beyond the image edge; ignored when out of range
   task automatic send_stray_load();
      int row, col;
      row = $urandom_range(0, MAX_ROWS - 1);
      col = $urandom_range(0, MAX_COLS - 1);
      if (img_rows < MAX_ROWS && $urandom_range(0, 1) == 1)
         row = $urandom_range(img_rows, MAX_ROWS - 1);
      else if (img_cols < MAX_COLS)
         col = $urandom_range(img_cols, MAX_COLS - 1);
      send_load(row, col, $urandom_range(0, 24'hFFFFFF));
   endtask

   task automatic send_random_eval();
      int r, fx, fy, sx, sy, thr;
      r  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 4);
      fx = pick_coord(img_cols, r, 1'b1);
      fy = pick_coord(img_rows, r, 1'b0);
      if ($urandom_range(0, 7) == 0) begin
         sx = fx;
         sy = fy;
      end else begin
         sx = pick_coord(img_cols, r, 1'b1);
         sy = pick_coord(img_rows, r, 1'b0);
      end
      case ($urandom_range(0, 7))
         0:       thr = 0;
         1:       thr = $urandom_range(0, 65535) - 32768;
         2:       thr = $urandom_range(0, 1) ? 32767 : -32768;
         default: thr = $urandom_range(0, 4095) - 2048;
      endcase
      send_eval(fx, fy, sx, sy, r, thr);
   endtask

   // Pause until every expected byte has come and the block has gone quiet
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (busy || bytes_outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      burst_left = 0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input int data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(data);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // New register setting; large axes load only a band at each edge
   task automatic configure(input int cols_raw, input int rows_raw, input int lrn_raw);
      settle();
      csr_write(CSR_IMAGE_COLS, cols_raw);
      csr_write(CSR_IMAGE_ROWS, rows_raw);
      csr_write(CSR_LEARNERS, lrn_raw);
      img_cols = clip_dim(cols_raw, MAX_COLS);
      img_rows = clip_dim(rows_raw, MAX_ROWS);
      for (int i = 0; i < MAX_ROWS; i++)
         row_ok[i] = (i < img_rows) &&
                     (img_rows <= FULL_LOAD_MAX || i < BAND || i >= img_rows - BAND);
      for (int i = 0; i < MAX_COLS; i++)
         col_ok[i] = (i < img_cols) &&
                     (img_cols <= FULL_LOAD_MAX || i < BAND || i >= img_cols - BAND);
   endtask

   // style 0: integral of random pixels, 1: flat image, 2: raw 24-bit values
   task automatic load_image(input int style);
      int unsigned px, run;
      px = $urandom_range(0, 255);
      for (int y = 0; y < img_rows; y++) begin
         run = 0;
         for (int x = 0; x < img_cols; x++) begin
            if (style == 2) begin
               case ($urandom_range(0, 7))
                  0:       image[y][x] = 0;
                  1:       image[y][x] = 24'hFFFFFF;
                  default: image[y][x] = $urandom_range(0, 24'hFFFFFF);
               endcase
            end else if (y == 0 || x == 0) begin
               image[y][x] = 0;
            end else begin
               if (style == 0) px = $urandom_range(0, 255);
               run += px;
               image[y][x] = image[y-1][x] + run;
            end
         end
      end
      for (int y = 0; y < img_rows; y++)
         for (int x = 0; x < img_cols; x++)
            if (row_ok[y] && col_ok[x]) begin
               send_load(y, x, image[y][x]);
               if ($urandom_range(0, 15) == 0) send_stray_load();
            end
   endtask

   // Mostly learners over loaded cells, with rewrites and stray loads mixed in
   task automatic run_random(input int n_evals, input int style);
      int done, y, x;
      done = 0;
      while (done < n_evals) begin
         case ($urandom_range(0, 9))
            0: begin
               y = $urandom_range(0, img_rows - 1);
               while (!row_ok[y]) y = $urandom_range(0, img_rows - 1);
               x = $urandom_range(0, img_cols - 1);
               while (!col_ok[x]) x = $urandom_range(0, img_cols - 1);
               if (style == 2) image[y][x] = $urandom_range(0, 24'hFFFFFF);
               send_load(y, x, image[y][x]);
            end
            1: send_stray_load();
            default: begin
               send_random_eval();
               done++;
            end
         endcase
         if ($urandom_range(0, 299) == 0) settle();
      end
   endtask

   initial begin
      int cols_raw, rows_raw, lrn_raw, style;
      reset      = 1'b1;
      start      = 1'b0;
      req_item   = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      burst_left = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: smallest image, every box clamps onto the same four cells
      configure(2, 2, 8);
      send_load(0, 0, 0);
      send_load(0, 1, 0);
      send_load(1, 0, 0);
      send_load(1, 1, 24'hFFFFFF);
      send_load(255, 255, 24'hFFFFFF);
      send_load(2, 0, 24'hABCDEF);
      send_eval(-2048, -2048, 2047, 2047, 0, -32768);
      send_eval(2047, 2047, -2048, -2048, 63, 32767);
      send_eval(0, 0, 1, 1, 0, 0);
      send_eval(0, 0, 0, 0, 63, -1);
      send_eval(1, 0, 0, 1, 5, 1);
      send_eval(-1, 2, 3, -3, 1, -64);
      send_eval(100, -100, -100, 100, 31, 64);
      send_eval(2047, -2048, 0, 0, 32, -2);
      send_load(1, 1, 0);
      send_load(0, 0, 24'hFFFFFF);
      repeat (8) send_random_eval();

      // Random phases over a spread of register settings
      for (int p = 1; p <= 11; p++) begin
         cols_raw = $urandom_range(3, 14);
         rows_raw = $urandom_range(3, 14);
         lrn_raw  = 8 * $urandom_range(1, 4);
         case (p)
            2: begin cols_raw = 256;   rows_raw = 256; lrn_raw = 512;  end
            3: begin cols_raw = 0;     rows_raw = 300; lrn_raw = 1023; end
            4: begin rows_raw = 0;     lrn_raw  = 0;                   end
            5: begin cols_raw = 511;   lrn_raw  = 13;                  end
            6: begin rows_raw = 511;   lrn_raw  = 100;                 end
            7: begin cols_raw = 'h203; rows_raw = 1;   lrn_raw = 255;  end
            8: begin cols_raw = 257;   rows_raw = 2;   lrn_raw = 8;    end
            default: ;
         endcase
         configure(cols_raw, rows_raw, lrn_raw);
         if (p == 1) csr_write(CSR_SPARE, $urandom_range(0, 1023));
         style = (p == 2) ? 0 : p % 3;
         load_image(style);
         run_random($urandom_range(40, 80), style);
      end

      settle();
      if (mismatch_count == 0 && bytes_outstanding == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
